// ===== rtl/assert_macros.svh =====
// assertion helpers used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pmdt_pkg.sv =====
`timescale 1ns / 1ps

package pmdt_pkg;

  localparam int unsigned ID_W  = 64;
  localparam int unsigned OC_W  = 8;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned DUP_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(256);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic {
    CMD_MARK   = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [ID_W-1:0]  msg_id;
    logic [OC_W-1:0]  outcome_in;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [OC_W-1:0]  found_outcome;
    logic [CNT_W-1:0] processed_count;
    logic [DUP_W-1:0] duplicate_count;
  } rsp_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

  typedef struct packed {
    logic            valid;
    logic            hit;
    logic [OC_W-1:0] outcome;
  } store_rsp_t;

endpackage

// ===== rtl/pmdt_store.sv =====
`timescale 1ns / 1ps

module pmdt_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pmdt_pkg::store_ctl_t        ctl,
  input  logic [AW-1:0]               wr_addr,
  input  logic [pmdt_pkg::ID_W-1:0]   wr_id,
  input  logic [pmdt_pkg::OC_W-1:0]   wr_oc,
  input  logic [AW-1:0]               rd_addr,
  input  logic [pmdt_pkg::ID_W-1:0]   key,
  output pmdt_pkg::store_rsp_t        rsp
);

  logic [pmdt_pkg::ID_W-1:0] id_mem [DEPTH];
  logic [pmdt_pkg::OC_W-1:0] oc_mem [DEPTH];

  logic [pmdt_pkg::ID_W-1:0] rd_id;
  logic [pmdt_pkg::OC_W-1:0] rd_oc;
  logic                      rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      id_mem[wr_addr] <= wr_id;
      oc_mem[wr_addr] <= wr_oc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_id <= id_mem[rd_addr];
      rd_oc <= oc_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= ctl.rd_en;
    end
  end

  // the single shared identifier comparator
  always_comb begin
    rsp.valid   = rd_valid;
    rsp.hit     = rd_valid && (rd_id == key);
    rsp.outcome = rd_oc;
  end

endmodule

// ===== rtl/processed_message_dedup_table_top.sv =====
`timescale 1ns / 1ps
// results: a zero identifier is answered in the cycle after the start transfer; any other item
//   gives its done strobe once the scan ends on a hit or after the last stored entry is read
// throughput: a zero identifier every cycle; no new item is taken while a scan is busy;
//   the scan reads one stored entry per cycle through one read port and one comparator
// reset: synchronous active-high rst empties the table, clears both counters and loads
//   capacity_limit with 256; table memory is not cleared; results cannot be stalled

module processed_message_dedup_table_top #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  pmdt_pkg::req_t               req,
  // result strobe
  output logic                         done,
  output pmdt_pkg::rsp_t               rsp,
  // capacity limit register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pmdt_pkg::CNT_W-1:0]   cfg_data
);

`include "assert_macros.svh"

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // entry count can never pass what the count field holds
  localparam int unsigned DEPTH_CLIP =
      (TABLE_DEPTH > int'(pmdt_pkg::CNT_MAX)) ? int'(pmdt_pkg::CNT_MAX) : TABLE_DEPTH;
  localparam logic [pmdt_pkg::CNT_W-1:0] DEPTH_LIM = pmdt_pkg::CNT_W'(DEPTH_CLIP);

  // sequencer state
  pmdt_pkg::state_t state, state_next;

  // latched command
  pmdt_pkg::cmd_t                cmd_q;
  logic [pmdt_pkg::ID_W-1:0]     id_q;
  logic [pmdt_pkg::OC_W-1:0]     oc_q;

  // scan index: next entry to read
  logic [pmdt_pkg::CNT_W-1:0]    idx;

  // architectural state
  logic [pmdt_pkg::CNT_W-1:0]    entry_count, entry_count_next;
  logic [pmdt_pkg::DUP_W-1:0]    dup_count, dup_count_next;
  logic [pmdt_pkg::CNT_W-1:0]    cap_limit;

  // result register
  pmdt_pkg::rsp_t                rsp_q, rsp_next;
  logic                          done_q, done_next;

  // control
  logic                          acc;
  logic                          acc_invalid;
  logic                          more;
  logic                          finish;
  logic                          room;
  logic [pmdt_pkg::CNT_W-1:0]    eff_limit;
  pmdt_pkg::store_ctl_t          st_ctl;
  pmdt_pkg::store_rsp_t          st_rsp;

  assign busy      = (state != pmdt_pkg::S_IDLE);
  assign cfg_ready = !busy;
  assign done      = done_q;
  assign rsp       = rsp_q;

  assign acc         = start && !busy;
  assign acc_invalid = acc && (req.msg_id == '0);

  // effective limit is the smaller of the register and the table depth
  assign eff_limit = (cap_limit > DEPTH_LIM) ? DEPTH_LIM : cap_limit;
  assign room      = (entry_count < eff_limit);

  // entries left to read, and end of scan: a hit, or nothing in flight and nothing left
  assign more   = (idx < entry_count);
  assign finish = (state == pmdt_pkg::S_SCAN) && (st_rsp.hit || (!st_rsp.valid && !more));

  // table memory and comparator
  pmdt_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (st_ctl),
    .wr_addr (AW'(entry_count)),
    .wr_id   (id_q),
    .wr_oc   (oc_q),
    .rd_addr (AW'(idx)),
    .key     (id_q),
    .rsp     (st_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pmdt_pkg::S_IDLE: begin
        if (acc && !acc_invalid) begin
          state_next = pmdt_pkg::S_SCAN;
        end
      end
      pmdt_pkg::S_SCAN: begin
        if (finish) begin
          state_next = pmdt_pkg::S_IDLE;
        end
      end
      default: state_next = pmdt_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs and result formation
  always_comb begin
    st_ctl.rd_en     = 1'b0;
    st_ctl.wr_en     = 1'b0;
    done_next        = 1'b0;
    entry_count_next = entry_count;
    dup_count_next   = dup_count;
    rsp_next.status          = pmdt_pkg::ST_OK;
    rsp_next.found_outcome   = '0;
    rsp_next.processed_count = entry_count;
    rsp_next.duplicate_count = dup_count;

    unique case (state)
      pmdt_pkg::S_IDLE: begin
        // zero identifier is refused without a scan
        if (acc_invalid) begin
          done_next       = 1'b1;
          rsp_next.status = pmdt_pkg::ST_INVALID;
        end
      end
      pmdt_pkg::S_SCAN: begin
        // one read per cycle until a hit or until the stored entries are exhausted
        st_ctl.rd_en = more && !st_rsp.hit;
        if (finish) begin
          done_next = 1'b1;
          if (st_rsp.hit) begin
            if (cmd_q == pmdt_pkg::CMD_MARK) begin
              // duplicate mark, saturating counter
              if (dup_count != '1) begin
                dup_count_next = dup_count + pmdt_pkg::DUP_W'(1);
              end
              rsp_next.status = pmdt_pkg::ST_EXISTS;
            end else begin
              rsp_next.status        = pmdt_pkg::ST_OK;
              rsp_next.found_outcome = st_rsp.outcome;
            end
          end else begin
            if (cmd_q == pmdt_pkg::CMD_MARK) begin
              if (room) begin
                // append at the end of the table
                st_ctl.wr_en     = 1'b1;
                entry_count_next = entry_count + pmdt_pkg::CNT_W'(1);
                rsp_next.status  = pmdt_pkg::ST_OK;
              end else begin
                rsp_next.status = pmdt_pkg::ST_FULL;
              end
            end else begin
              rsp_next.status = pmdt_pkg::ST_NOT_FOUND;
            end
          end
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase

    rsp_next.processed_count = entry_count_next;
    rsp_next.duplicate_count = dup_count_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pmdt_pkg::S_IDLE;
      done_q      <= 1'b0;
      entry_count <= '0;
      dup_count   <= '0;
      cap_limit   <= pmdt_pkg::CAP_RESET;
    end else begin
      state       <= state_next;
      done_q      <= done_next;
      entry_count <= entry_count_next;
      dup_count   <= dup_count_next;
      if (cfg_valid && cfg_ready) begin
        cap_limit <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_q <= req.cmd;
      id_q  <= req.msg_id;
      oc_q  <= req.outcome_in;
    end
    if (acc) begin
      idx <= '0;
    end else if (st_ctl.rd_en) begin
      idx <= idx + pmdt_pkg::CNT_W'(1);
    end
    if (done_next) begin
      rsp_q <= rsp_next;
    end
  end

  // a result strobe only follows a resolved scan or a refused zero identifier
  `ASSERT_CLKD(a_done_source, clk, rst, done |-> $past(finish || acc_invalid), "done without cause")
  // every result leaves the sequencer idle
  `ASSERT_CLKD(a_done_idle, clk, rst, done |-> !busy, "busy while a result is shown")
  // the table never grows past the clipped table depth once the count is known
  `ASSERT_ALWAYS(a_count_bound, clk, !$isunknown(entry_count) |-> entry_count <= DEPTH_LIM, "entry count beyond table depth")
  // the table grows only with a successful mark reported in the same cycle
  `ASSERT_CLKD(a_count_grow, clk, rst, (!$past(rst) && entry_count != $past(entry_count)) |-> (done && rsp.status == pmdt_pkg::ST_OK), "entry count moved without an ok result")

endmodule
